// ===== hw/rtl/msplit_pkg.sv =====
// ----------------------------------------------------------------------------
// msplit_pkg
// Shared types and constants of the meshlet splitter: beat structs,
// configuration register map, record kinds and sequencer states.
// ----------------------------------------------------------------------------
package msplit_pkg;

    localparam int CNT_W   = 9;
    localparam int TCNT_W  = 10;
    localparam int TNUM_W  = 30;
    localparam int ID_W    = 32;
    localparam int LOC_W   = 8;
    localparam int PADDR_W = 4;

    localparam int PRIMITIVE_SLOTS = 512;
    localparam logic [TCNT_W-1:0] PRIM_MAX =
        TCNT_W'((PRIMITIVE_SLOTS < 1023) ? PRIMITIVE_SLOTS : 1023);

    localparam logic [PADDR_W-1:0] ADDR_VERTEX_LIMIT    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_PRIMITIVE_LIMIT = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_FIRST_INDEX     = 4'h8;

    localparam logic [CNT_W-1:0]  VERTEX_LIMIT_RST    = 9'd256;
    localparam logic [TCNT_W-1:0] PRIMITIVE_LIMIT_RST = 10'd512;

    localparam logic [1:0] REC_VERTEX   = 2'd0;
    localparam logic [1:0] REC_TRIANGLE = 2'd1;
    localparam logic [1:0] REC_CLOSE    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] vertex_a;
        logic [ID_W-1:0] vertex_b;
        logic [ID_W-1:0] vertex_c;
        logic            last_triangle;
    } tri_in_t;

    typedef struct packed {
        logic [1:0]          record_kind;
        logic [ID_W-1:0]     vertex_id;
        logic [31:0]         index_slot;
        logic [3*LOC_W-1:0]  packed_local;
        logic [TNUM_W-1:0]   primitive_id;
        logic [CNT_W-1:0]    meshlet_vertices;
        logic [TCNT_W-1:0]   meshlet_primitives;
        logic                last;
    } rec_out_t;

    typedef struct packed {
        logic [CNT_W-1:0]  vertex_limit;
        logic [TCNT_W-1:0] primitive_limit;
        logic [31:0]       first_index;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CLOSE_PRE,
        ST_VERT_A,
        ST_VERT_B,
        ST_VERT_C,
        ST_TRI,
        ST_CLOSE_POST
    } state_t;

endpackage

// ===== hw/rtl/msplit_cfg.sv =====
// ----------------------------------------------------------------------------
// msplit_cfg
// APB register file: vertex limit, primitive limit, first index position.
// ----------------------------------------------------------------------------
module msplit_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msplit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output msplit_pkg::cfg_t              cfg
);
    import msplit_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vertex_limit    <= VERTEX_LIMIT_RST;
            cfg_reg.primitive_limit <= PRIMITIVE_LIMIT_RST;
            cfg_reg.first_index     <= '0;
        end else if (wr_en) begin
            unique case (paddr)
                ADDR_VERTEX_LIMIT:    cfg_reg.vertex_limit    <= pwdata[CNT_W-1:0];
                ADDR_PRIMITIVE_LIMIT: cfg_reg.primitive_limit <= pwdata[TCNT_W-1:0];
                ADDR_FIRST_INDEX:     cfg_reg.first_index     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_VERTEX_LIMIT:    prdata = {{(32-CNT_W){1'b0}}, cfg_reg.vertex_limit};
            ADDR_PRIMITIVE_LIMIT: prdata = {{(32-TCNT_W){1'b0}}, cfg_reg.primitive_limit};
            ADDR_FIRST_INDEX:     prdata = cfg_reg.first_index;
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/meshlet_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// meshlet_splitter_unit
// Greedy meshlet builder: one triangle per beat, vertex store in one RAM.
// ----------------------------------------------------------------------------
// Sequence: an accept state, a search of the vertex RAM (one entry per cycle,
// all three corners compared at once), a decide state, then an optional close
// record, a vertex record for each corner not yet stored, a triangle record and,
// after the last triangle, a close record; each record waits for a free output.
// A new triangle is taken only in idle, after the last one's records are emitted.
// Reset: synchronous, active low; clears counters and limits to defaults.
// The vertex RAM is not cleared; only entries below vertex_count are read.
// ----------------------------------------------------------------------------
module meshlet_splitter_unit #(
    parameter int VERTEX_SLOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  msplit_pkg::tri_in_t            s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output msplit_pkg::rec_out_t           m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msplit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import msplit_pkg::*;

    localparam int AW = $clog2(VERTEX_SLOTS);

    cfg_t cfg;

    msplit_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [ID_W-1:0] vtx_mem [VERTEX_SLOTS];
    logic [ID_W-1:0] rd_data_reg;

    state_t state_reg, state_next;

    tri_in_t          tri_reg;
    logic [AW:0]      issue_reg;
    logic             pend_reg;
    logic [AW-1:0]    cmp_addr_reg;
    logic             fa_reg, fb_reg, fc_reg;
    logic [LOC_W-1:0] la_reg, lb_reg, lc_reg;
    logic             na_reg, nb_reg, nc_reg;
    logic [31:0]      base_reg;

    logic [CNT_W-1:0]  vcount_reg;
    logic [TCNT_W-1:0] tcount_reg;
    logic              pfull_reg;
    logic [TNUM_W-1:0] tnum_reg;

    logic     m_valid_reg;
    rec_out_t m_data_reg;

    logic [CNT_W-1:0]  vlim;
    logic [TCNT_W-1:0] plim;
    logic              dup_b, dup_ca, dup_cb;
    logic [1:0]        fresh;
    logic              close_pre;
    logic              rd_en;
    logic              scan_done;
    logic              out_free;
    logic              emit;
    logic              wr_en;
    logic [ID_W-1:0]   wr_id;
    rec_out_t          rec;
    logic [LOC_W-1:0]  pb, pc;
    logic [TCNT_W-1:0] tcount_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        vlim = cfg.vertex_limit;
        if (vlim < CNT_W'(3)) vlim = CNT_W'(3);
        if (vlim > CNT_W'(VERTEX_SLOTS)) vlim = CNT_W'(VERTEX_SLOTS);
        plim = cfg.primitive_limit;
        if (plim == '0) plim = TCNT_W'(1);
        if (plim > PRIM_MAX) plim = PRIM_MAX;
    end

    assign dup_b  = (tri_reg.vertex_b == tri_reg.vertex_a);
    assign dup_ca = (tri_reg.vertex_c == tri_reg.vertex_a);
    assign dup_cb = (tri_reg.vertex_c == tri_reg.vertex_b);
    assign fresh  = 2'(!fa_reg) + 2'(!fb_reg && !dup_b) + 2'(!fc_reg && !dup_ca && !dup_cb);
    assign close_pre = (tcount_reg != '0) &&
                       (pfull_reg || tcount_reg >= plim ||
                        ({1'b0, vcount_reg} + 10'(fresh)) > {1'b0, vlim});

    assign rd_en     = (state_reg == ST_SCAN) && (CNT_W'(issue_reg) < vcount_reg);
    assign scan_done = (state_reg == ST_SCAN) && !rd_en && !pend_reg;
    assign pb = dup_b ? la_reg : lb_reg;
    assign pc = dup_ca ? la_reg : (dup_cb ? pb : lc_reg);
    assign tcount_inc = tcount_reg + TCNT_W'(1);

    always_comb begin
        state_next = state_reg;
        emit  = 1'b0;
        wr_en = 1'b0;
        wr_id = tri_reg.vertex_a;
        rec   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = close_pre ? ST_CLOSE_PRE : ST_VERT_A;
            end
            ST_CLOSE_PRE: begin
                rec.record_kind        = REC_CLOSE;
                rec.meshlet_vertices   = vcount_reg;
                rec.meshlet_primitives = tcount_reg;
                if (out_free) begin
                    emit = 1'b1;
                    state_next = ST_VERT_A;
                end
            end
            ST_VERT_A: begin
                rec.record_kind = REC_VERTEX;
                rec.vertex_id   = tri_reg.vertex_a;
                rec.index_slot  = base_reg;
                wr_id = tri_reg.vertex_a;
                if (!na_reg) begin
                    state_next = ST_VERT_B;
                end else if (out_free) begin
                    emit = 1'b1;
                    wr_en = 1'b1;
                    state_next = ST_VERT_B;
                end
            end
            ST_VERT_B: begin
                rec.record_kind = REC_VERTEX;
                rec.vertex_id   = tri_reg.vertex_b;
                rec.index_slot  = base_reg + 32'd1;
                wr_id = tri_reg.vertex_b;
                if (!nb_reg) begin
                    state_next = ST_VERT_C;
                end else if (out_free) begin
                    emit = 1'b1;
                    wr_en = 1'b1;
                    state_next = ST_VERT_C;
                end
            end
            ST_VERT_C: begin
                rec.record_kind = REC_VERTEX;
                rec.vertex_id   = tri_reg.vertex_c;
                rec.index_slot  = base_reg + 32'd2;
                wr_id = tri_reg.vertex_c;
                if (!nc_reg) begin
                    state_next = ST_TRI;
                end else if (out_free) begin
                    emit = 1'b1;
                    wr_en = 1'b1;
                    state_next = ST_TRI;
                end
            end
            ST_TRI: begin
                rec.record_kind  = REC_TRIANGLE;
                rec.packed_local = {pc, pb, la_reg};
                rec.primitive_id = tnum_reg;
                rec.last         = !tri_reg.last_triangle;
                if (out_free) begin
                    emit = 1'b1;
                    state_next = tri_reg.last_triangle ? ST_CLOSE_POST : ST_IDLE;
                end
            end
            ST_CLOSE_POST: begin
                rec.record_kind        = REC_CLOSE;
                rec.meshlet_vertices   = vcount_reg;
                rec.meshlet_primitives = tcount_reg;
                rec.last               = 1'b1;
                if (out_free) begin
                    emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= vtx_mem[issue_reg[AW-1:0]];
        end
        if (wr_en) begin
            vtx_mem[vcount_reg[AW-1:0]] <= wr_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= '0;
            tcount_reg  <= '0;
            pfull_reg   <= 1'b0;
            tnum_reg    <= '0;
        end else begin
            pend_reg <= rd_en;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                priority case (state_reg)
                    ST_CLOSE_PRE, ST_CLOSE_POST: begin
                        vcount_reg <= '0;
                        tcount_reg <= '0;
                        pfull_reg  <= 1'b0;
                        if (state_reg == ST_CLOSE_POST) tnum_reg <= '0;
                    end
                    ST_VERT_A, ST_VERT_B, ST_VERT_C: begin
                        vcount_reg <= vcount_reg + CNT_W'(1);
                    end
                    ST_TRI: begin
                        tcount_reg <= tcount_inc;
                        tnum_reg   <= tnum_reg + TNUM_W'(1);
                        if (tcount_inc >= plim) pfull_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= rec;
        end
        unique case (state_reg)
            ST_IDLE: begin
                tri_reg   <= s_data;
                issue_reg <= '0;
                fa_reg    <= 1'b0;
                fb_reg    <= 1'b0;
                fc_reg    <= 1'b0;
            end
            ST_SCAN: begin
                if (rd_en) issue_reg <= issue_reg + (AW+1)'(1);
                cmp_addr_reg <= issue_reg[AW-1:0];
                if (pend_reg) begin
                    if (rd_data_reg == tri_reg.vertex_a) begin
                        fa_reg <= 1'b1;
                        la_reg <= LOC_W'(cmp_addr_reg);
                    end
                    if (rd_data_reg == tri_reg.vertex_b) begin
                        fb_reg <= 1'b1;
                        lb_reg <= LOC_W'(cmp_addr_reg);
                    end
                    if (rd_data_reg == tri_reg.vertex_c) begin
                        fc_reg <= 1'b1;
                        lc_reg <= LOC_W'(cmp_addr_reg);
                    end
                end
            end
            ST_DECIDE: begin
                na_reg   <= !(fa_reg && !close_pre);
                nb_reg   <= !(fb_reg && !close_pre) && !dup_b;
                nc_reg   <= !(fc_reg && !close_pre) && !dup_ca && !dup_cb;
                base_reg <= cfg.first_index + {1'b0, tnum_reg, 1'b0} + {2'b00, tnum_reg};
            end
            ST_VERT_A: if (wr_en) la_reg <= LOC_W'(vcount_reg);
            ST_VERT_B: if (wr_en) lb_reg <= LOC_W'(vcount_reg);
            ST_VERT_C: if (wr_en) lc_reg <= LOC_W'(vcount_reg);
            default: ;
        endcase
    end

endmodule
